>>> rtl/core/skf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

   localparam int VALUE_W     = 32;
   localparam int GAIN_W      = 17;
   localparam int CSR_INDEX_W = 8;
   localparam int DIV_STEPS   = 17;
   localparam int COUNT_W     = 5;
   localparam int MUL_A_W     = 18;
   localparam int MUL_B_W     = 34;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_ESTIMATE  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_VARIANCE  = 8'd3;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_PREDICT = 8'b0000_0010,
      ST_SETUP   = 8'b0000_0100,
      ST_DIVIDE  = 8'b0000_1000,
      ST_MUL_EST = 8'b0001_0000,
      ST_EST     = 8'b0010_0000,
      ST_VAR     = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/skf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skf_req_if;
   import skf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] sample;
   logic                      restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);

endinterface

`default_nettype wire

>>> rtl/core/skf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skf_rsp_if;
   import skf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] estimate;
   logic [VALUE_W-1:0]        variance;
   logic [GAIN_W-1:0]         gain;
   logic                      saturated;

   modport source (output valid, output estimate, output variance, output gain,
                   output saturated, input ready);
   modport sink   (input valid, input estimate, input variance, input gain,
                   input saturated, output ready);

endinterface

`default_nettype wire

>>> rtl/core/skf_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skf_csr_if;
   import skf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [VALUE_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/core/scalar_kalman_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Scalar Kalman filter for a random-walk state in Q16.16 with a Q1.16 gain. Each request
// (sample, restart) yields one response holding the new estimate, the updated variance,
// the gain used and a saturation flag. After acceptance a request passes through
// prediction, setup, the 17-step restoring divider that forms the gain, one quotient bit
// per cycle, the estimate product, estimate rounding (while the shared 18 x 34 bit
// multiplier forms the variance product), variance rounding and write-back, which loads
// the response register and returns req_if.ready; write-back waits while an earlier
// response is still held and not taken. req_if.ready is high only while idle; a finished
// response may wait in its output register while the next request is accepted.
// csr_if.ready is always high; Q and R take effect at the next request, the initial
// estimate and variance at a request with restart set (reset clears the CSR registers
// and the current estimate and variance to zero). Writes to indexes beyond the four
// registers are ignored.
module scalar_kalman_filter
   import skf_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   skf_req_if.sink     req_if,
   skf_rsp_if.source   rsp_if,
   skf_csr_if.sink     csr_if
);

   localparam logic signed [36:0] EST_MAX = 37'sd2147483647;
   localparam logic signed [36:0] EST_MIN = -37'sd2147483648;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 52'sd32768;

   state_type                  state_ff, state_in;
   logic [VALUE_W-1:0]         q_ff, q_in;
   logic [VALUE_W-1:0]         r_ff, r_in;
   logic signed [VALUE_W-1:0]  init_est_ff, init_est_in;
   logic [VALUE_W-1:0]         init_var_ff, init_var_in;
   logic signed [VALUE_W-1:0]  cur_est_ff, cur_est_in;
   logic [VALUE_W-1:0]         cur_var_ff, cur_var_in;
   logic signed [VALUE_W-1:0]  sample_ff, sample_in;
   logic                       restart_ff, restart_in;
   logic [VALUE_W-1:0]         pp_ff, pp_in;
   logic                       sat_ff, sat_in;
   logic [VALUE_W:0]           denom_ff, denom_in;
   logic [VALUE_W+1:0]         rem_ff, rem_in;
   logic [GAIN_W-1:0]          quo_ff, quo_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [VALUE_W:0]    diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [VALUE_W-1:0]  est_ff, est_in;
   logic [VALUE_W-1:0]         var_ff, var_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_est_ff, rsp_est_in;
   logic [VALUE_W-1:0]         rsp_var_ff, rsp_var_in;
   logic [GAIN_W-1:0]          rsp_gain_ff, rsp_gain_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic                       req_fire;
   logic                       csr_fire;
   logic [VALUE_W:0]           pp_sum;
   logic [VALUE_W-1:0]         var_src;
   logic                       rem_ge;
   logic [VALUE_W+1:0]         rem_sub;
   logic                       quo_bit;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [PROD_W-1:0]   prod_rnd;
   logic signed [36:0]         est_wide;
   logic [35:0]                var_wide;
   logic                       out_free;

   assign req_fire      = req_if.valid && req_if.ready;
   assign csr_fire      = csr_if.valid && csr_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.estimate  = rsp_est_ff;
   assign rsp_if.variance  = rsp_var_ff;
   assign rsp_if.gain      = rsp_gain_ff;
   assign rsp_if.saturated = rsp_sat_ff;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // restart reload and prediction
   assign var_src = restart_ff ? init_var_ff : cur_var_ff;
   assign pp_sum  = {1'b0, var_src} + {1'b0, q_ff};

   // restoring divide step
   assign rem_ge  = rem_ff >= {1'b0, denom_ff};
   assign rem_sub = rem_ge ? (rem_ff - {1'b0, denom_ff}) : rem_ff;
   assign quo_bit = rem_ge;

   // shared multiplier
   always_comb begin
      if (state_ff == ST_MUL_EST) begin
         mul_a = signed'({1'b0, quo_ff});
         mul_b = signed'({diff_ff[VALUE_W], diff_ff});
      end else begin
         mul_a = signed'({1'b0, GAIN_ONE - quo_ff});
         mul_b = signed'({2'b00, pp_ff});
      end
   end
   assign mul_p = mul_a * mul_b;

   assign prod_rnd = prod_ff + ROUND_HALF;
   assign est_wide = signed'({prod_rnd[PROD_W-1], prod_rnd[PROD_W-1:16]})
                     + 37'(cur_est_ff);
   assign var_wide = prod_rnd[PROD_W-1:16];

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      init_est_in  = init_est_ff;
      init_var_in  = init_var_ff;
      cur_est_in   = cur_est_ff;
      cur_var_in   = cur_var_ff;
      sample_in    = sample_ff;
      restart_in   = restart_ff;
      pp_in        = pp_ff;
      sat_in       = sat_ff;
      denom_in     = denom_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      count_in     = count_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      est_in       = est_ff;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_fire) begin
         unique case (csr_if.index)
            CSR_PROCESS_NOISE:     q_in        = csr_if.data;
            CSR_MEASUREMENT_NOISE: r_in        = csr_if.data;
            CSR_INITIAL_ESTIMATE:  init_est_in = signed'(csr_if.data);
            CSR_INITIAL_VARIANCE:  init_var_in = csr_if.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sample_in  = req_if.sample;
               restart_in = req_if.restart;
               state_in   = ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            if (restart_ff) begin
               cur_est_in = init_est_ff;
               cur_var_in = init_var_ff;
            end
            sat_in   = pp_sum[VALUE_W];
            pp_in    = pp_sum[VALUE_W] ? '1 : pp_sum[VALUE_W-1:0];
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            denom_in = {1'b0, pp_ff} + {1'b0, r_ff};
            rem_in   = {2'b00, pp_ff};
            quo_in   = '0;
            count_in = '0;
            diff_in  = 33'(sample_ff) - 33'(cur_est_ff);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in   = {rem_sub[VALUE_W:0], 1'b0};
            count_in = count_ff + 1'b1;
            if (count_ff == COUNT_W'(DIV_STEPS - 1)) begin
               quo_in   = (denom_ff == '0) ? '0 : {quo_ff[GAIN_W-2:0], quo_bit};
               state_in = ST_MUL_EST;
            end else begin
               quo_in = {quo_ff[GAIN_W-2:0], quo_bit};
            end
         end
         ST_MUL_EST: begin
            prod_in  = mul_p;
            state_in = ST_EST;
         end
         ST_EST: begin
            if (est_wide > EST_MAX) begin
               est_in = EST_MAX[VALUE_W-1:0];
               sat_in = 1'b1;
            end else if (est_wide < EST_MIN) begin
               est_in = EST_MIN[VALUE_W-1:0];
               sat_in = 1'b1;
            end else begin
               est_in = est_wide[VALUE_W-1:0];
            end
            prod_in  = mul_p;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            var_in   = (|var_wide[35:VALUE_W]) ? '1 : var_wide[VALUE_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cur_est_in   = est_ff;
               cur_var_in   = var_ff;
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_ff;
               rsp_var_in   = var_ff;
               rsp_gain_in  = quo_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff         <= '0;
         r_ff         <= '0;
         init_est_ff  <= '0;
         init_var_ff  <= '0;
         cur_est_ff   <= '0;
         cur_var_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         init_est_ff  <= init_est_in;
         init_var_ff  <= init_var_in;
         cur_est_ff   <= cur_est_in;
         cur_var_ff   <= cur_var_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      restart_ff  <= restart_in;
      pp_ff       <= pp_in;
      sat_ff      <= sat_in;
      denom_ff    <= denom_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      count_ff    <= count_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      est_ff      <= est_in;
      var_ff      <= var_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import skf_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 154;
   localparam int SETTLE_TICKS = 30;

   typedef struct {
      logic signed [VALUE_W-1:0] sample;
      logic                      restart;
   } sample_request_type;

   typedef struct {
      logic signed [VALUE_W-1:0] estimate;
      logic [VALUE_W-1:0]        variance;
      logic [GAIN_W-1:0]         gain;
      logic                      saturated;
   } filter_result_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] index;
      logic [VALUE_W-1:0]     data;
   } register_write_type;

   logic clock;
   logic reset;

   skf_req_if req_if ();
   skf_rsp_if rsp_if ();
   skf_csr_if csr_if ();

   scalar_kalman_filter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // filter state and registers as the block should hold them
   logic [VALUE_W-1:0]        process_noise_q     = '0;
   logic [VALUE_W-1:0]        measurement_noise_r = '0;
   logic signed [VALUE_W-1:0] init_estimate       = '0;
   logic [VALUE_W-1:0]        init_variance       = '0;
   logic signed [VALUE_W-1:0] est_state           = '0;
   logic [VALUE_W-1:0]        var_state           = '0;

   sample_request_type pending_samples[$];
   register_write_type pending_writes[$];
   filter_result_type  expected_results[$];

   int  samples_outstanding = 0;
   int  writes_outstanding  = 0;
   int  failures            = 0;
   int  req_gap             = 0;
   int  rsp_stall           = 0;
   int  quiet_ticks         = 0;
   bit  quiet_tail          = 1'b0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic filter_result_type kalman_update(
      input logic signed [VALUE_W-1:0] sample,
      input logic restart);
      filter_result_type res;
      logic [63:0]    pp;
      logic [63:0]    denom;
      logic [63:0]    var_next;
      longint         gain_q;
      longint         diff;
      longint         corr;
      longint         est_next;
      logic           clipped;
      clipped = 1'b0;
      if (restart) begin
         est_state = init_estimate;
         var_state = init_variance;
      end
      pp = {32'd0, var_state} + {32'd0, process_noise_q};
      if (pp > 64'hFFFF_FFFF) begin
         pp      = 64'hFFFF_FFFF;
         clipped = 1'b1;
      end
      denom = pp + {32'd0, measurement_noise_r};
      if (denom == 64'd0)
         gain_q = 0;
      else
         gain_q = longint'((pp << 16) / denom);
      if (gain_q > 65536)
         gain_q = 65536;
      diff     = longint'(sample) - longint'(est_state);
      corr     = (gain_q * diff + 32768) >>> 16;
      est_next = longint'(est_state) + corr;
      if (est_next > longint'(32'sh7FFF_FFFF)) begin
         est_next = longint'(32'sh7FFF_FFFF);
         clipped  = 1'b1;
      end else if (est_next < longint'(32'sh8000_0000)) begin
         est_next = longint'(32'sh8000_0000);
         clipped  = 1'b1;
      end
      var_next = ((64'd65536 - 64'(gain_q)) * pp + 64'd32768) >> 16;
      if (var_next > 64'hFFFF_FFFF)
         var_next = 64'hFFFF_FFFF;
      est_state     = 32'(est_next);
      var_state     = var_next[31:0];
      res.estimate  = 32'(est_next);
      res.variance  = var_next[31:0];
      res.gain      = gain_q[GAIN_W-1:0];
      res.saturated = clipped;
      return res;
   endfunction

   function automatic logic [VALUE_W-1:0] noise_value();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         3: return $urandom_range(1, 32'h0004_0000);
         4: return $urandom >> $urandom_range(4, 28);
         default: return $urandom_range(0, 32'h0000_FFFF);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] estimate_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [VALUE_W-1:0] data);
      register_write_type w;
      w.index = index;
      w.data  = data;
      pending_writes.push_back(w);
      writes_outstanding++;
   endtask

   task automatic send_sample(input logic [VALUE_W-1:0] sample, input logic restart);
      sample_request_type s;
      s.sample  = sample;
      s.restart = restart;
      pending_samples.push_back(s);
      samples_outstanding++;
   endtask

   task automatic wait_idle();
      while (writes_outstanding != 0 || samples_outstanding != 0 ||
             expected_results.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : csr_driver
      register_write_type w;
      if (reset) begin
         csr_if.valid <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_PROCESS_NOISE:     process_noise_q     = csr_if.data;
               CSR_MEASUREMENT_NOISE: measurement_noise_r = csr_if.data;
               CSR_INITIAL_ESTIMATE:  init_estimate       = csr_if.data;
               CSR_INITIAL_VARIANCE:  init_variance       = csr_if.data;
               default: ;
            endcase
            writes_outstanding--;
         end
         if (!csr_if.valid || csr_if.ready) begin
            if (pending_writes.size() != 0) begin
               w = pending_writes.pop_front();
               csr_if.valid <= 1'b1;
               csr_if.index <= w.index;
               csr_if.data  <= w.data;
            end else begin
               csr_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : request_driver
      sample_request_type s;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(kalman_update(req_if.sample, req_if.restart));
            samples_outstanding--;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap != 0) begin
               req_if.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (pending_samples.size() != 0) begin
               if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                  req_if.valid <= 1'b0;
                  req_gap      <= $urandom_range(0, 15);
               end else begin
                  s = pending_samples.pop_front();
                  req_if.valid   <= 1'b1;
                  req_if.sample  <= s.sample;
                  req_if.restart <= s.restart;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      filter_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.estimate !== want.estimate) begin
                  $error("estimate: expected %0d, got %0d", want.estimate, rsp_if.estimate);
                  failures++;
               end
               if (rsp_if.variance !== want.variance) begin
                  $error("variance: expected %0d, got %0d", want.variance, rsp_if.variance);
                  failures++;
               end
               if (rsp_if.gain !== want.gain) begin
                  $error("gain: expected %0d, got %0d", want.gain, rsp_if.gain);
                  failures++;
               end
               if (rsp_if.saturated !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d", want.saturated,
                         rsp_if.saturated);
                  failures++;
               end
            end
         end
         if (rsp_stall != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
         end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= $urandom_range(0, 15);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_ticks <= 0;
      end else if (quiet_ticks >= STALL_LIMIT) begin
         $display("scalar_kalman_filter regression: fail");
         $finish;
      end else begin
         quiet_ticks <= quiet_ticks + 1;
      end
   end

   initial begin : sequencer
      logic [VALUE_W-1:0] walk;
      logic [VALUE_W-1:0] sample;
      logic [VALUE_W-1:0] ie;
      req_if.valid   = 1'b0;
      req_if.sample  = '0;
      req_if.restart = 1'b0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      reset          = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all registers zero: divisor is zero
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h1234_5678, 1'b0);
      wait_idle();

      write_register(CSR_PROCESS_NOISE, 32'h0001_0000);
      write_register(CSR_MEASUREMENT_NOISE, 32'h0001_0000);
      write_register(CSR_INITIAL_ESTIMATE, 32'h8000_0000);
      write_register(CSR_INITIAL_VARIANCE, 32'hFFFF_FFFF);
      write_register(8'd4, 32'hFFFF_FFFF);
      write_register(8'd255, 32'hFFFF_FFFF);
      wait_idle();
      // predicted variance clips
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'h0001_8000, 1'b0);
      wait_idle();

      // unit gain
      write_register(CSR_PROCESS_NOISE, 32'hFFFF_FFFF);
      write_register(CSR_MEASUREMENT_NOISE, 32'h0000_0000);
      write_register(CSR_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
      write_register(CSR_INITIAL_VARIANCE, 32'h0000_0000);
      wait_idle();
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      wait_idle();

      // zero predicted variance, widest divisor
      write_register(CSR_PROCESS_NOISE, 32'h0000_0000);
      write_register(CSR_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
      write_register(CSR_INITIAL_ESTIMATE, 32'h0000_0000);
      wait_idle();
      send_sample(32'h7FFF_FFFF, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      wait_idle();

      // initial values only apply on restart
      write_register(CSR_PROCESS_NOISE, 32'h0000_0100);
      write_register(CSR_MEASUREMENT_NOISE, 32'h0003_0000);
      write_register(CSR_INITIAL_ESTIMATE, 32'h0005_0000);
      write_register(CSR_INITIAL_VARIANCE, 32'h0002_0000);
      wait_idle();
      send_sample(32'h0004_0000, 1'b0);
      send_sample(32'h0004_0000, 1'b1);
      send_sample(32'hFFFF_0000, 1'b0);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1)
            quiet_tail = 1'b1;
         ie = estimate_value();
         write_register(CSR_INITIAL_VARIANCE, noise_value());
         write_register(CSR_PROCESS_NOISE, noise_value());
         if ($urandom_range(0, 3) == 0)
            write_register(8'($urandom_range(4, 255)), $urandom);
         write_register(CSR_MEASUREMENT_NOISE, noise_value());
         write_register(CSR_INITIAL_ESTIMATE, ie);
         wait_idle();
         walk = ie;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            walk = walk + $urandom_range(0, 8192) - 4096;
            case ($urandom_range(0, 19))
               0: sample = 32'h7FFF_FFFF;
               1: sample = 32'h8000_0000;
               2, 3, 4: sample = $urandom;
               default: sample = walk + $urandom_range(0, 262144) - 131072;
            endcase
            if (n == 0)
               send_sample(sample, 1'($urandom_range(0, 1)));
            else
               send_sample(sample, $urandom_range(0, 24) == 0);
         end
         wait_idle();
      end

      repeat (SETTLE_TICKS) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("scalar_kalman_filter regression: pass");
      end else begin
         $display("scalar_kalman_filter regression: fail");
      end
      $finish;
   end

endmodule
